### rtl/lorenz_attractor_oscillator_assert.svh
// Assertion macros shared by the oscillator RTL.
`ifndef LORENZ_ATTRACTOR_OSCILLATOR_ASSERT_SVH
`define LORENZ_ATTRACTOR_OSCILLATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LAO_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LAO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/lao_pkg.sv
// Types, widths and constants shared by the oscillator controller and datapath.
package lao_pkg;

    // Field and register widths
    localparam int CV_W       = 21;
    localparam int SIGMA_W    = 21;
    localparam int BETA_W     = 18;
    localparam int RHO_W      = 23;
    localparam int PITCH_W    = 17;
    localparam int STEP_W     = 17;
    localparam int POS_W      = 32;
    localparam int VOLT_W     = 32;
    localparam int QFRAC      = 16;

    // Stream and configuration port widths
    localparam int IN_W       = 88;
    localparam int OUT_W      = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    // Datapath widths
    localparam int OP_W   = 34;          // multiplier operand
    localparam int PROD_W = 2 * OP_W;    // full product
    localparam int SPLIT  = 24;          // low slice of a split operand
    localparam int ACC_W  = PROD_W - SPLIT;
    localparam int D_W    = 48;          // saturated derivative
    localparam int INC_W  = 50;          // scaled increment
    localparam int SUM_W  = 52;          // wide intermediate before saturation
    localparam int KSUM_W = 26;          // knob plus scaled voltage

    // Register reset values
    localparam logic [SIGMA_W-1:0] SIGMA_RESET = 21'd655360;
    localparam logic [BETA_W-1:0]  BETA_RESET  = 18'd174763;
    localparam logic [RHO_W-1:0]   RHO_RESET   = 23'd1835008;
    localparam logic [PITCH_W-1:0] PITCH_RESET = 17'd32768;
    localparam logic [STEP_W-1:0]  STEP_RESET  = 17'd557;
    localparam logic signed [POS_W-1:0] POS_RESET = 32'sd65536;

    // Q16.16 gains
    localparam logic signed [OP_W-1:0] Q_TENTH = 34'sd6554;
    localparam logic signed [OP_W-1:0] X_GAIN  = 34'sd14418;
    localparam logic signed [OP_W-1:0] Y_GAIN  = 34'sd10748;

    // Parameter ranges
    localparam logic signed [KSUM_W-1:0] SIGMA_MIN = 26'sd196608;
    localparam logic signed [KSUM_W-1:0] SIGMA_MAX = 26'sd1966080;
    localparam logic signed [KSUM_W-1:0] BETA_MIN  = 26'sd32768;
    localparam logic signed [KSUM_W-1:0] BETA_MAX  = 26'sd196608;
    localparam logic signed [KSUM_W-1:0] RHO_MIN   = 26'sd851968;
    localparam logic signed [KSUM_W-1:0] RHO_MAX   = 26'sd5242880;
    localparam logic signed [KSUM_W-1:0] PITCH_MIN = 26'sd66;
    localparam logic signed [KSUM_W-1:0] PITCH_MAX = 26'sd65536;

    // Rounding and saturation limits
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'sd1 <<< (QFRAC - 1));
    localparam logic signed [SUM_W-1:0]  D_MAX   = SUM_W'((64'sd1 <<< (D_W - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0]  D_MIN   = SUM_W'(-(64'sd1 <<< (D_W - 1)));
    localparam logic signed [SUM_W-1:0]  POS_MAX = SUM_W'((64'sd1 <<< (POS_W - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0]  POS_MIN = SUM_W'(-(64'sd1 <<< (POS_W - 1)));

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIGMA = 3'd0,
        CFG_BETA  = 3'd1,
        CFG_RHO   = 3'd2,
        CFG_PITCH = 3'd3,
        CFG_STEP  = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        C_X,
        C_Y,
        C_Z
    } coord_t;

    typedef enum logic [3:0] {
        M_NONE,
        M_SIGMA_CV,
        M_BETA_CV,
        M_RHO_CV,
        M_PITCH_CV,
        M_DX,
        M_DY,
        M_XY,
        M_BZ,
        M_DLO,
        M_DHI,
        M_ILO,
        M_IHI,
        M_VX,
        M_VY
    } mul_op_t;

    typedef enum logic [3:0] {
        P_NONE,
        P_SIGMA,
        P_BETA,
        P_RHO,
        P_PITCH,
        P_XY,
        P_DX,
        P_DY,
        P_DZ,
        P_LO,
        P_INC,
        P_POS,
        P_VX,
        P_VY
    } post_op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CV_SIGMA,
        S_CV_BETA,
        S_CV_RHO,
        S_CV_PITCH,
        S_XY,
        S_BZ,
        S_DX,
        S_DY,
        S_DX_LO,
        S_DX_HI,
        S_DX_INC,
        S_IX_LO,
        S_IX_HI,
        S_DY_LO,
        S_DY_HI,
        S_DY_INC,
        S_IY_LO,
        S_IY_HI,
        S_DZ_LO,
        S_DZ_HI,
        S_DZ_INC,
        S_IZ_LO,
        S_IZ_HI,
        S_VX,
        S_VY,
        S_OUT
    } state_t;

    typedef struct packed {
        logic     load;
        mul_op_t  mul_op;
        coord_t   mul_coord;
        post_op_t post_op;
        coord_t   post_coord;
    } dp_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_sts_t;

endpackage

### rtl/lao_ctrl.sv
// Sequencer that walks one Euler step through the shared multiplier.
`include "lorenz_attractor_oscillator_assert.svh"

module lao_ctrl import lao_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Each state issues at most one multiply and post-processes at most the previous product.
    always_comb begin
        state_next = state_reg;
        cmd = '{load: 1'b0, mul_op: M_NONE, mul_coord: C_X,
                post_op: P_NONE, post_coord: C_X};
        unique case (state_reg)
            S_IDLE: begin
                cmd.load = in_valid;
                if (in_valid) begin
                    state_next = S_CV_SIGMA;
                end
            end
            S_CV_SIGMA: begin
                cmd.mul_op = M_SIGMA_CV;
                state_next = S_CV_BETA;
            end
            S_CV_BETA: begin
                cmd.mul_op  = M_BETA_CV;
                cmd.post_op = P_SIGMA;
                state_next  = S_CV_RHO;
            end
            S_CV_RHO: begin
                cmd.mul_op  = M_RHO_CV;
                cmd.post_op = P_BETA;
                state_next  = S_CV_PITCH;
            end
            S_CV_PITCH: begin
                cmd.mul_op  = M_PITCH_CV;
                cmd.post_op = P_RHO;
                state_next  = S_XY;
            end
            S_XY: begin
                cmd.mul_op  = M_XY;
                cmd.post_op = P_PITCH;
                state_next  = S_BZ;
            end
            S_BZ: begin
                cmd.mul_op  = M_BZ;
                cmd.post_op = P_XY;
                state_next  = S_DX;
            end
            S_DX: begin
                cmd.mul_op  = M_DX;
                cmd.post_op = P_DZ;
                state_next  = S_DY;
            end
            S_DY: begin
                cmd.mul_op  = M_DY;
                cmd.post_op = P_DX;
                state_next  = S_DX_LO;
            end
            S_DX_LO: begin
                cmd.mul_op    = M_DLO;
                cmd.mul_coord = C_X;
                cmd.post_op   = P_DY;
                state_next    = S_DX_HI;
            end
            S_DX_HI: begin
                cmd.mul_op    = M_DHI;
                cmd.mul_coord = C_X;
                cmd.post_op   = P_LO;
                state_next    = S_DX_INC;
            end
            S_DX_INC: begin
                cmd.post_op = P_INC;
                state_next  = S_IX_LO;
            end
            S_IX_LO: begin
                cmd.mul_op = M_ILO;
                state_next = S_IX_HI;
            end
            S_IX_HI: begin
                cmd.mul_op  = M_IHI;
                cmd.post_op = P_LO;
                state_next  = S_DY_LO;
            end
            S_DY_LO: begin
                cmd.mul_op     = M_DLO;
                cmd.mul_coord  = C_Y;
                cmd.post_op    = P_POS;
                cmd.post_coord = C_X;
                state_next     = S_DY_HI;
            end
            S_DY_HI: begin
                cmd.mul_op    = M_DHI;
                cmd.mul_coord = C_Y;
                cmd.post_op   = P_LO;
                state_next    = S_DY_INC;
            end
            S_DY_INC: begin
                cmd.post_op = P_INC;
                state_next  = S_IY_LO;
            end
            S_IY_LO: begin
                cmd.mul_op = M_ILO;
                state_next = S_IY_HI;
            end
            S_IY_HI: begin
                cmd.mul_op  = M_IHI;
                cmd.post_op = P_LO;
                state_next  = S_DZ_LO;
            end
            S_DZ_LO: begin
                cmd.mul_op     = M_DLO;
                cmd.mul_coord  = C_Z;
                cmd.post_op    = P_POS;
                cmd.post_coord = C_Y;
                state_next     = S_DZ_HI;
            end
            S_DZ_HI: begin
                cmd.mul_op    = M_DHI;
                cmd.mul_coord = C_Z;
                cmd.post_op   = P_LO;
                state_next    = S_DZ_INC;
            end
            S_DZ_INC: begin
                cmd.post_op = P_INC;
                state_next  = S_IZ_LO;
            end
            S_IZ_LO: begin
                cmd.mul_op = M_ILO;
                state_next = S_IZ_HI;
            end
            S_IZ_HI: begin
                cmd.mul_op  = M_IHI;
                cmd.post_op = P_LO;
                state_next  = S_VX;
            end
            S_VX: begin
                cmd.mul_op     = M_VX;
                cmd.post_op    = P_POS;
                cmd.post_coord = C_Z;
                state_next     = S_VY;
            end
            S_VY: begin
                cmd.mul_op  = M_VY;
                cmd.post_op = P_VX;
                state_next  = S_OUT;
            end
            S_OUT: begin
                // Hold until the output register can take the result.
                if (!sts.out_busy) begin
                    cmd.post_op = P_VY;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    `LAO_ASSERT_NEXT(a_accept_starts, aclk, aresetn, in_valid && in_ready, state_reg == S_CV_SIGMA, "accepted transaction did not start the sequence")
    `LAO_ASSERT_NEXT(a_out_done, aclk, aresetn, (state_reg == S_OUT) && !sts.out_busy, state_reg == S_IDLE, "sequence did not return to idle after the result")
    `LAO_ASSERT_IMPL(a_hold_result, aclk, aresetn, (state_reg == S_OUT) && sts.out_busy, cmd.post_op == P_NONE, "result issued while the output register is occupied")

endmodule

### rtl/lao_dp.sv
// Datapath: knob registers, state, shared multiplier, post-processing and output register.
`include "lorenz_attractor_oscillator_assert.svh"

module lao_dp import lao_pkg::*; (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  dp_cmd_t                      cmd,
    output dp_sts_t                      sts,
    input  logic signed [CV_W-1:0]       sigma_cv,
    input  logic signed [CV_W-1:0]       beta_cv,
    input  logic signed [CV_W-1:0]       rho_cv,
    input  logic signed [CV_W-1:0]       pitch_cv,
    input  logic                         cfg_valid,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [VOLT_W-1:0]     x_voltage,
    output logic signed [VOLT_W-1:0]     y_voltage
);

    function automatic logic signed [D_W-1:0] sat_d(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] c;
        c = (v > D_MAX) ? D_MAX : ((v < D_MIN) ? D_MIN : v);
        return c[D_W-1:0];
    endfunction

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] c;
        c = (v > POS_MAX) ? POS_MAX : ((v < POS_MIN) ? POS_MIN : v);
        return c[POS_W-1:0];
    endfunction

    function automatic logic signed [KSUM_W-1:0] clamp_k(input logic signed [KSUM_W-1:0] v,
                                                         input logic signed [KSUM_W-1:0] lo,
                                                         input logic signed [KSUM_W-1:0] hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Knob registers
    logic [SIGMA_W-1:0] sigma_knob_reg;
    logic [BETA_W-1:0]  beta_knob_reg;
    logic [RHO_W-1:0]   rho_knob_reg;
    logic [PITCH_W-1:0] pitch_knob_reg;
    logic [STEP_W-1:0]  step_scale_reg;

    // Captured voltages and effective parameters
    logic signed [CV_W-1:0] sigma_cv_reg, beta_cv_reg, rho_cv_reg, pitch_cv_reg;
    logic [SIGMA_W-1:0] sigma_eff_reg;
    logic [BETA_W-1:0]  beta_eff_reg;
    logic [RHO_W-1:0]   rho_eff_reg;
    logic [PITCH_W-1:0] pitch_eff_reg;

    // Attractor state and intermediates
    logic signed [POS_W-1:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic signed [D_W-1:0]   dx_reg, dy_reg, dz_reg, t_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [INC_W-1:0] inc_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [POS_W-1:0] vx_hold_reg;

    // Output register
    logic                     out_valid_reg;
    logic signed [VOLT_W-1:0] x_out_reg, y_out_reg;

    // Combinational signals
    logic signed [OP_W-1:0]   mul_a, mul_b;
    logic signed [D_W-1:0]    d_sel;
    logic signed [POS_W:0]    y_m_x;
    logic signed [POS_W+1:0]  rho_m_z;
    logic signed [PROD_W-1:0] rnd_full, hi_shift, wide_sum, wide_rnd;
    logic signed [SUM_W-1:0]  dy_sum, dz_sum, pos_new;
    logic signed [POS_W-1:0]  pos_sel;
    logic signed [KSUM_W-1:0] k_base, k_lo, k_hi, k_sum, k_clamp;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sigma_knob_reg <= SIGMA_RESET;
            beta_knob_reg  <= BETA_RESET;
            rho_knob_reg   <= RHO_RESET;
            pitch_knob_reg <= PITCH_RESET;
            step_scale_reg <= STEP_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SIGMA: sigma_knob_reg <= cfg_data[SIGMA_W-1:0];
                CFG_BETA:  beta_knob_reg  <= cfg_data[BETA_W-1:0];
                CFG_RHO:   rho_knob_reg   <= cfg_data[RHO_W-1:0];
                CFG_PITCH: pitch_knob_reg <= cfg_data[PITCH_W-1:0];
                CFG_STEP:  step_scale_reg <= cfg_data[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sigma_cv_reg <= sigma_cv;
            beta_cv_reg  <= beta_cv;
            rho_cv_reg   <= rho_cv;
            pitch_cv_reg <= pitch_cv;
        end
    end

    // Multiplier operand selection
    assign y_m_x   = (POS_W+1)'(pos_y_reg) - (POS_W+1)'(pos_x_reg);
    assign rho_m_z = (POS_W+2)'(rho_eff_reg) - (POS_W+2)'(pos_z_reg);

    always_comb begin
        unique case (cmd.mul_coord)
            C_X:     d_sel = dx_reg;
            C_Y:     d_sel = dy_reg;
            C_Z:     d_sel = dz_reg;
            default: d_sel = dx_reg;
        endcase
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_op)
            M_NONE: begin
            end
            M_SIGMA_CV: begin
                mul_a = OP_W'(sigma_cv_reg);
                mul_b = Q_TENTH;
            end
            M_BETA_CV: begin
                mul_a = OP_W'(beta_cv_reg);
                mul_b = Q_TENTH;
            end
            M_RHO_CV: begin
                mul_a = OP_W'(rho_cv_reg);
                mul_b = Q_TENTH;
            end
            M_PITCH_CV: begin
                mul_a = OP_W'(pitch_cv_reg);
                mul_b = Q_TENTH;
            end
            M_DX: begin
                mul_a = OP_W'(y_m_x);
                mul_b = OP_W'(sigma_eff_reg);
            end
            M_DY: begin
                mul_a = OP_W'(pos_x_reg);
                mul_b = OP_W'(rho_m_z);
            end
            M_XY: begin
                mul_a = OP_W'(pos_x_reg);
                mul_b = OP_W'(pos_y_reg);
            end
            M_BZ: begin
                mul_a = OP_W'(pos_z_reg);
                mul_b = OP_W'(beta_eff_reg);
            end
            M_DLO: begin
                mul_a = OP_W'(d_sel[SPLIT-1:0]);
                mul_b = OP_W'(step_scale_reg);
            end
            M_DHI: begin
                mul_a = OP_W'($signed(d_sel[D_W-1:SPLIT]));
                mul_b = OP_W'(step_scale_reg);
            end
            M_ILO: begin
                mul_a = OP_W'(inc_reg[SPLIT-1:0]);
                mul_b = OP_W'(pitch_eff_reg);
            end
            M_IHI: begin
                mul_a = OP_W'($signed(inc_reg[INC_W-1:SPLIT]));
                mul_b = OP_W'(pitch_eff_reg);
            end
            M_VX: begin
                mul_a = OP_W'(pos_x_reg);
                mul_b = X_GAIN;
            end
            M_VY: begin
                mul_a = OP_W'(pos_y_reg);
                mul_b = Y_GAIN;
            end
            default: begin
            end
        endcase
    end

    // Hold the product when no multiply is issued
    always_ff @(posedge aclk) begin
        if (cmd.mul_op != M_NONE) begin
            prod_reg <= mul_a * mul_b;
        end
    end

    // Rounding of a single product and of a split (low + high << SPLIT) product
    assign rnd_full = (prod_reg + ROUND_HALF) >>> QFRAC;
    assign hi_shift = $signed({prod_reg[ACC_W-1:0], {SPLIT{1'b0}}});
    assign wide_sum = PROD_W'(acc_reg) + hi_shift;
    assign wide_rnd = (wide_sum + ROUND_HALF) >>> QFRAC;

    assign dy_sum = rnd_full[SUM_W-1:0] - SUM_W'(pos_y_reg);
    assign dz_sum = SUM_W'(t_reg) - rnd_full[SUM_W-1:0];

    always_comb begin
        unique case (cmd.post_coord)
            C_X:     pos_sel = pos_x_reg;
            C_Y:     pos_sel = pos_y_reg;
            C_Z:     pos_sel = pos_z_reg;
            default: pos_sel = pos_x_reg;
        endcase
    end

    assign pos_new = SUM_W'(pos_sel) + wide_rnd[SUM_W-1:0];

    // Knob plus scaled voltage, clamped to the parameter range
    always_comb begin
        k_base = '0;
        k_lo   = '0;
        k_hi   = '0;
        unique case (cmd.post_op)
            P_SIGMA: begin
                k_base = KSUM_W'(sigma_knob_reg);
                k_lo   = SIGMA_MIN;
                k_hi   = SIGMA_MAX;
            end
            P_BETA: begin
                k_base = KSUM_W'(beta_knob_reg);
                k_lo   = BETA_MIN;
                k_hi   = BETA_MAX;
            end
            P_RHO: begin
                k_base = KSUM_W'(rho_knob_reg);
                k_lo   = RHO_MIN;
                k_hi   = RHO_MAX;
            end
            P_PITCH: begin
                k_base = KSUM_W'(pitch_knob_reg);
                k_lo   = PITCH_MIN;
                k_hi   = PITCH_MAX;
            end
            default: begin
            end
        endcase
    end

    assign k_sum   = k_base + rnd_full[KSUM_W-1:0];
    assign k_clamp = clamp_k(k_sum, k_lo, k_hi);

    always_ff @(posedge aclk) begin
        unique case (cmd.post_op)
            P_SIGMA: sigma_eff_reg <= k_clamp[SIGMA_W-1:0];
            P_BETA:  beta_eff_reg  <= k_clamp[BETA_W-1:0];
            P_RHO:   rho_eff_reg   <= k_clamp[RHO_W-1:0];
            P_PITCH: pitch_eff_reg <= k_clamp[PITCH_W-1:0];
            P_XY:    t_reg         <= rnd_full[D_W-1:0];
            P_DX:    dx_reg        <= sat_d(rnd_full[SUM_W-1:0]);
            P_DY:    dy_reg        <= sat_d(dy_sum);
            P_DZ:    dz_reg        <= sat_d(dz_sum);
            P_LO:    acc_reg       <= prod_reg[ACC_W-1:0];
            P_INC:   inc_reg       <= wide_rnd[INC_W-1:0];
            P_VX:    vx_hold_reg   <= sat_pos(rnd_full[SUM_W-1:0]);
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg <= POS_RESET;
            pos_y_reg <= POS_RESET;
            pos_z_reg <= POS_RESET;
        end else if (cmd.post_op == P_POS) begin
            unique case (cmd.post_coord)
                C_X:     pos_x_reg <= sat_pos(pos_new);
                C_Y:     pos_y_reg <= sat_pos(pos_new);
                C_Z:     pos_z_reg <= sat_pos(pos_new);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.post_op == P_VY) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.post_op == P_VY) begin
            x_out_reg <= vx_hold_reg;
            y_out_reg <= sat_pos(rnd_full[SUM_W-1:0]);
        end
    end

    assign sts.out_busy = out_valid_reg && !out_ready;
    assign out_valid    = out_valid_reg;
    assign x_voltage    = x_out_reg;
    assign y_voltage    = y_out_reg;

    `LAO_ASSERT_IMPL(a_out_free, aclk, aresetn, cmd.post_op == P_VY, !out_valid_reg || out_ready, "result written over a pending transaction")
    `LAO_ASSERT_IMPL(a_valid_src, aclk, aresetn, $rose(out_valid_reg), $past(cmd.post_op == P_VY), "output valid rose without a result")
    `LAO_ASSERT_NEXT(a_pitch_range, aclk, aresetn, cmd.post_op == P_PITCH, (pitch_eff_reg >= PITCH_W'(PITCH_MIN)) && (pitch_eff_reg <= PITCH_W'(PITCH_MAX)), "effective pitch outside its range")

endmodule

### rtl/lorenz_attractor_oscillator.sv
// Top level of the Lorenz attractor oscillator: stream ports, config port, sequencer and datapath.
//
// Lorenz attractor oscillator, one forward-Euler step per input transaction. Each input
// transaction carries four signed Q5.16 control voltages (sigma, beta, rho, pitch); each is scaled
// by 0.1, added to its knob register and clamped to the parameter's range. The point
// (x, y, z), reset to (1.0, 1.0, 1.0), then advances by the Lorenz derivative times
// step_scale times pitch, every coordinate saturating at the 32-bit limits, and one result
// transaction returns 0.22*x and 0.164*y in Q16.16. A new item is taken only while the
// sequencer is idle, with s_tready high; a 26-step sequence then drives all 22 products
// of the step (wide ones split into two halves) through a single shared 34 x 34 signed
// multiplier with a registered product, and the next item waits for that sequence. The result goes
// to an output register, so a new item is taken while the previous result waits on
// m_tready; the sequence stalls at its final step only while that register is still full.
// Knob registers are written through the cfg port (always ready), by the user only while the block
// is idle (the block itself does not enforce this): index 0 sigma_knob, 1 beta_knob, 2 rho_knob,
// 3 pitch_knob, 4 step_scale; other indexes are dropped. Reset is synchronous and active low.
module lorenz_attractor_oscillator import lao_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_W-1:0]       s_tdata,   // sigma_cv[20:0], beta_cv[41:21],
                                             // rho_cv[62:42], pitch_cv[83:63], zero pad
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata,   // x_voltage[31:0], y_voltage[63:32]
    // Configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    // Unpack the input transaction fields
    logic signed [CV_W-1:0] sigma_cv, beta_cv, rho_cv, pitch_cv;
    logic signed [VOLT_W-1:0] x_voltage, y_voltage;

    assign sigma_cv = s_tdata[CV_W-1:0];
    assign beta_cv  = s_tdata[2*CV_W-1:CV_W];
    assign rho_cv   = s_tdata[3*CV_W-1:2*CV_W];
    assign pitch_cv = s_tdata[4*CV_W-1:3*CV_W];

    // Knob writes are always taken
    assign cfg_ready = 1'b1;

    lao_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lao_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .sigma_cv  (sigma_cv),
        .beta_cv   (beta_cv),
        .rho_cv    (rho_cv),
        .pitch_cv  (pitch_cv),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .x_voltage (x_voltage),
        .y_voltage (y_voltage)
    );

    // Pack the result transaction, x in the low word
    assign m_tdata = {y_voltage, x_voltage};

endmodule

### tb/sv/tb_lorenz_attractor_oscillator.sv
// Self-checking testbench for lorenz_attractor_oscillator: random CV streams with a Q16.16 predictor.
`timescale 1ns / 1ps

module tb_lorenz_attractor_oscillator import lao_pkg::*; ();

    // Bench timing and run length
    localparam int RESET_CYCLES   = 9;
    localparam int SETTLE_CYCLES  = 64;     // wait for stray results before the verdict
    localparam int STALL_LIMIT    = 4000;   // cycles without any transaction
    localparam int NUM_PHASES     = 10;
    localparam int PHASE_ITEMS    = 73;

    // Q16.16 arithmetic constants
    localparam int FRAC_BITS  = 16;
    localparam int TENTH      = 6554;
    localparam int X_SCALE    = 14418;
    localparam int Y_SCALE    = 10748;
    localparam int POINT_INIT = 65536;

    // Effective parameter ranges, Q16.16
    localparam int SIGMA_LO = 196608;
    localparam int SIGMA_HI = 1966080;
    localparam int BETA_LO  = 32768;
    localparam int BETA_HI  = 196608;
    localparam int RHO_LO   = 851968;
    localparam int RHO_HI   = 5242880;
    localparam int PITCH_LO = 66;
    localparam int PITCH_HI = 65536;
    localparam int STEP_LO  = 1;
    localparam int STEP_HI  = 65536;

    // Register values after reset
    localparam int SIGMA_INIT = 655360;
    localparam int BETA_INIT  = 174763;
    localparam int RHO_INIT   = 1835008;
    localparam int PITCH_INIT = 32768;
    localparam int STEP_INIT  = 557;

    // Control voltage corners
    localparam int CV_SPAN = 655360;
    localparam logic signed [CV_W-1:0] CV_MAX     = 21'sd655360;
    localparam logic signed [CV_W-1:0] CV_MIN     = -21'sd655360;
    localparam logic signed [CV_W-1:0] CV_RAW_MAX = 21'h0FFFFF;
    localparam logic signed [CV_W-1:0] CV_RAW_MIN = 21'h100000;

    // Wide signed type: every intermediate of the step fits with room to spare
    typedef logic signed [95:0] wide_t;
    localparam wide_t ROUND_HALF = 96'sd32768;
    localparam wide_t DERIV_HI   = 96'sd140737488355327;
    localparam wide_t DERIV_LO   = -96'sd140737488355328;
    localparam wide_t I32_HI     = 96'sd2147483647;
    localparam wide_t I32_LO     = -96'sd2147483648;

    typedef struct {
        logic signed [CV_W-1:0] sigma_cv;
        logic signed [CV_W-1:0] beta_cv;
        logic signed [CV_W-1:0] rho_cv;
        logic signed [CV_W-1:0] pitch_cv;
    } cv_set_t;

    typedef struct {
        logic signed [VOLT_W-1:0] x_voltage;
        logic signed [VOLT_W-1:0] y_voltage;
    } volt_pair_t;

    typedef struct {
        int sigma;
        int beta;
        int rho;
        int pitch;
        int step;
    } knob_set_t;

    // DUT connections, all known from time zero
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_W-1:0]      m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Handshake flags sampled at the rising edge, read by the falling-edge drivers
    logic s_fire   = 1'b0;
    logic cfg_fire = 1'b0;

    // Stimulus queue and expected voltages
    cv_set_t    cv_pending_q[$];
    volt_pair_t volt_expect_q[$];

    // Idle percentages of the current phase
    int s_idle_pct  = 0;
    int m_stall_pct = 0;

    int err_count    = 0;
    int stall_cycles = 0;

    // Predictor copy of the knob registers and the attractor point
    logic [SIGMA_W-1:0]      kn_sigma;
    logic [BETA_W-1:0]       kn_beta;
    logic [RHO_W-1:0]        kn_rho;
    logic [PITCH_W-1:0]      kn_pitch;
    logic [STEP_W-1:0]       kn_step;
    logic signed [POS_W-1:0] pt_x;
    logic signed [POS_W-1:0] pt_y;
    logic signed [POS_W-1:0] pt_z;

    lorenz_attractor_oscillator u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Fixed-point predictor
    // ------------------------------------------------------------------

    // Round half up: add half an LSB, then floor via arithmetic shift.
    function automatic wide_t q_mul(input wide_t a, input wide_t b);
        return (a * b + ROUND_HALF) >>> FRAC_BITS;
    endfunction

    function automatic wide_t clamp_w(input wide_t v, input wide_t lo, input wide_t hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic signed [POS_W-1:0] sat32(input wide_t v);
        wide_t c;
        c = clamp_w(v, I32_LO, I32_HI);
        return c[POS_W-1:0];
    endfunction

    // Limit the derivative, scale by step and pitch, then add with saturation.
    function automatic logic signed [POS_W-1:0] advance_coord(
        input logic signed [POS_W-1:0] p, input wide_t d, input wide_t pitch,
        input wide_t scale);
        wide_t inc;
        wide_t base;
        inc  = q_mul(clamp_w(d, DERIV_LO, DERIV_HI), scale);
        inc  = q_mul(inc, pitch);
        base = p;
        return sat32(base + inc);
    endfunction

    // One Euler step of the attractor; updates the predicted point.
    function automatic volt_pair_t euler_step(input cv_set_t cv);
        wide_t sig, bet, rh, pit, scale, x, y, z, dx, dy, dz;
        wide_t k_sig, k_bet, k_rh, k_pit;
        logic signed [POS_W-1:0] nx, ny, nz;
        volt_pair_t v;
        k_sig = kn_sigma;
        k_bet = kn_beta;
        k_rh  = kn_rho;
        k_pit = kn_pitch;
        scale = kn_step;
        sig = clamp_w(k_sig + q_mul(cv.sigma_cv, TENTH), SIGMA_LO, SIGMA_HI);
        bet = clamp_w(k_bet + q_mul(cv.beta_cv, TENTH), BETA_LO, BETA_HI);
        rh  = clamp_w(k_rh + q_mul(cv.rho_cv, TENTH), RHO_LO, RHO_HI);
        pit = clamp_w(k_pit + q_mul(cv.pitch_cv, TENTH), PITCH_LO, PITCH_HI);
        // all three derivatives come from the point before the step
        x  = pt_x;
        y  = pt_y;
        z  = pt_z;
        dx = q_mul(sig, y - x);
        dy = q_mul(x, rh - z) - y;
        dz = q_mul(x, y) - q_mul(bet, z);
        nx = advance_coord(pt_x, dx, pit, scale);
        ny = advance_coord(pt_y, dy, pit, scale);
        nz = advance_coord(pt_z, dz, pit, scale);
        pt_x = nx;
        pt_y = ny;
        pt_z = nz;
        v.x_voltage = sat32(q_mul(nx, X_SCALE));
        v.y_voltage = sat32(q_mul(ny, Y_SCALE));
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [IN_W-1:0] pack_cv(input cv_set_t cv);
        return IN_W'({cv.pitch_cv, cv.rho_cv, cv.beta_cv, cv.sigma_cv});
    endfunction

    function automatic cv_set_t unpack_cv(input logic [IN_W-1:0] d);
        cv_set_t cv;
        cv.sigma_cv = d[CV_W-1:0];
        cv.beta_cv  = d[2*CV_W-1:CV_W];
        cv.rho_cv   = d[3*CV_W-1:2*CV_W];
        cv.pitch_cv = d[4*CV_W-1:3*CV_W];
        return cv;
    endfunction

    // Mostly in-range voltages, some raw 21-bit patterns, some corners.
    function automatic logic signed [CV_W-1:0] rand_cv();
        int pick;
        pick = $urandom_range(99, 0);
        if (pick < 70) return CV_W'(int'($urandom_range(2 * CV_SPAN, 0)) - CV_SPAN);
        if (pick < 90) return CV_W'($urandom());
        case ($urandom_range(4, 0))
            0: return CV_MAX;
            1: return CV_MIN;
            2: return CV_RAW_MAX;
            3: return CV_RAW_MIN;
            default: return '0;
        endcase
    endfunction

    task automatic push_cv(input logic signed [CV_W-1:0] s, input logic signed [CV_W-1:0] b,
                           input logic signed [CV_W-1:0] r, input logic signed [CV_W-1:0] p);
        cv_set_t cv;
        cv.sigma_cv = s;
        cv.beta_cv  = b;
        cv.rho_cv   = r;
        cv.pitch_cv = p;
        cv_pending_q.push_back(cv);
    endtask

    function automatic knob_set_t knobs_for_phase(input int phase);
        knob_set_t k;
        k.sigma = $urandom_range(SIGMA_HI, SIGMA_LO);
        k.beta  = $urandom_range(BETA_HI, BETA_LO);
        k.rho   = $urandom_range(RHO_HI, RHO_LO);
        k.pitch = $urandom_range(PITCH_HI, PITCH_LO);
        k.step  = $urandom_range(4096, 64);
        case (phase)
            // reset values written back explicitly
            1: k = '{SIGMA_INIT, BETA_INIT, RHO_INIT, PITCH_INIT, STEP_INIT};
            // every knob at its low end
            5: k = '{SIGMA_LO, BETA_LO, RHO_LO, PITCH_LO, STEP_LO};
            // knobs outside their ranges; zero step holds the point
            7: k = '{0, (1 << BETA_W) - 1, (1 << RHO_W) - 1, 0, 0};
            8: k = '{(1 << SIGMA_W) - 1, 0, 0, (1 << PITCH_W) - 1, 300};
            // every knob at its high end: the point runs into saturation
            10: k = '{SIGMA_HI, BETA_HI, RHO_HI, PITCH_HI, STEP_HI};
            default: ;
        endcase
        return k;
    endfunction

    // Write one register; bits above the register width carry junk.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value,
                             input int width);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value) | (CFG_DATA_W'($urandom()) << width);
        do @(negedge aclk); while (!cfg_fire);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_knobs(input knob_set_t k);
        logic [CFG_IDX_W-1:0] spare;
        spare = CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, int'(CFG_STEP) + 1));
        write_reg(CFG_SIGMA, k.sigma, SIGMA_W);
        write_reg(CFG_BETA, k.beta, BETA_W);
        write_reg(CFG_RHO, k.rho, RHO_W);
        write_reg(CFG_PITCH, k.pitch, PITCH_W);
        write_reg(CFG_STEP, k.step, STEP_W);
        // an index past the register list must be dropped
        write_reg(spare, $urandom(), CFG_DATA_W);
    endtask

    // Hold the sender until everything queued has gone through and come back.
    task automatic wait_drained();
        while (cv_pending_q.size() != 0 || volt_expect_q.size() != 0) @(negedge aclk);
    endtask

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // Drivers: change inputs on the falling edge
    // ------------------------------------------------------------------

    // Input stream: hold an unaccepted transaction, else offer the next one
    // unless this cycle is picked as idle.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_fire) begin
            // hold until accepted
        end else if (cv_pending_q.size() != 0 && $urandom_range(99, 0) >= s_idle_pct) begin
            s_tvalid <= 1'b1;
            s_tdata  <= pack_cv(cv_pending_q[0]);
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Result stream backpressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99, 0) >= m_stall_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: sample everything on the rising edge
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        volt_pair_t want;
        logic signed [VOLT_W-1:0] got_x;
        logic signed [VOLT_W-1:0] got_y;
        if (!aresetn) begin
            kn_sigma     = SIGMA_INIT;
            kn_beta      = BETA_INIT;
            kn_rho       = RHO_INIT;
            kn_pitch     = PITCH_INIT;
            kn_step      = STEP_INIT;
            pt_x         = POINT_INIT;
            pt_y         = POINT_INIT;
            pt_z         = POINT_INIT;
            s_fire       <= 1'b0;
            cfg_fire     <= 1'b0;
            stall_cycles <= 0;
        end else begin
            s_fire   <= s_tvalid && s_tready;
            cfg_fire <= cfg_valid && cfg_ready;

            // check the result first so an input taken on the same edge
            // never lines up against it
            if (m_tvalid && m_tready) begin
                got_x = m_tdata[VOLT_W-1:0];
                got_y = m_tdata[2*VOLT_W-1:VOLT_W];
                if (volt_expect_q.size() == 0) begin
                    report_error($sformatf("result with nothing expected: x=%0d y=%0d",
                                           got_x, got_y));
                end else begin
                    want = volt_expect_q.pop_front();
                    if (got_x !== want.x_voltage)
                        report_error($sformatf("x_voltage got %0d want %0d",
                                               got_x, want.x_voltage));
                    if (got_y !== want.y_voltage)
                        report_error($sformatf("y_voltage got %0d want %0d",
                                               got_y, want.y_voltage));
                end
            end

            // predict from what was actually on the bus
            if (s_tvalid && s_tready) begin
                volt_expect_q.push_back(euler_step(unpack_cv(s_tdata)));
                void'(cv_pending_q.pop_front());
            end

            // mirror register writes, masked to register width
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SIGMA: kn_sigma = cfg_data[SIGMA_W-1:0];
                    CFG_BETA:  kn_beta  = cfg_data[BETA_W-1:0];
                    CFG_RHO:   kn_rho   = cfg_data[RHO_W-1:0];
                    CFG_PITCH: kn_pitch = cfg_data[PITCH_W-1:0];
                    CFG_STEP:  kn_step  = cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end

            // watchdog: any transaction on any channel resets the count
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("tb_lorenz_attractor_oscillator: errors");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        knob_set_t k;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed items at the reset knobs, no idling.
        push_cv('0, '0, '0, '0);
        push_cv(CV_MAX, CV_MAX, CV_MAX, CV_MAX);
        push_cv(CV_MIN, CV_MIN, CV_MIN, CV_MIN);
        push_cv(CV_RAW_MAX, CV_RAW_MAX, CV_RAW_MAX, CV_RAW_MAX);
        push_cv(CV_RAW_MIN, CV_RAW_MIN, CV_RAW_MIN, CV_RAW_MIN);
        push_cv(CV_MAX, CV_MIN, CV_MAX, CV_MIN);
        push_cv(CV_MIN, CV_MAX, CV_MIN, CV_MAX);
        // small voltages exercise the rounding of the 0.1 scale
        push_cv(21'sd1, -21'sd1, 21'sd5, -21'sd5);
        push_cv(21'sd10, -21'sd10, -21'sd6, 21'sd6);
        // pitch pulled below its floor, rho pushed past its nominal span
        push_cv('0, '0, '0, CV_RAW_MIN);
        push_cv('0, '0, CV_RAW_MAX, '0);
        push_cv(CV_RAW_MIN, CV_RAW_MAX, '0, CV_RAW_MAX);
        repeat (6) push_cv(CV_W'($urandom()), CV_W'($urandom()),
                           CV_W'($urandom()), CV_W'($urandom()));
        wait_drained();

        // Random phases: retune the knobs while idle, rotate the idle pattern.
        for (int phase = 1; phase <= NUM_PHASES; phase++) begin
            k = knobs_for_phase(phase);
            apply_knobs(k);
            @(posedge aclk);
            case (phase % 4)
                1: begin s_idle_pct = 51; m_stall_pct = 0;  end
                2: begin s_idle_pct = 0;  m_stall_pct = 51; end
                3: begin s_idle_pct = 30; m_stall_pct = 30; end
                default: begin s_idle_pct = 0; m_stall_pct = 0; end
            endcase
            repeat (PHASE_ITEMS) push_cv(rand_cv(), rand_cv(), rand_cv(), rand_cv());
            wait_drained();
        end

        // let any stray result surface before the verdict
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (volt_expect_q.size() != 0)
            report_error($sformatf("%0d results never arrived", volt_expect_q.size()));
        if (err_count == 0) begin
            $display("tb_lorenz_attractor_oscillator: clean");
        end else begin
            $display("tb_lorenz_attractor_oscillator: errors");
        end
        $finish;
    end

endmodule
